>>> rtl/vpfa_pkg.sv
// Shared types, codes and stream field widths for the fit allocator.
// No dependencies; the scan unit, top level, checker and bench import this package.
package vpfa_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int SIZE_BITS_DEF  = 16;

    // Stream field widths, fixed by the interface.
    localparam int IN_SIZE_W   = 16;
    localparam int FIT_MODE_W  = 2;
    localparam int OUT_IDX_W   = 6;
    localparam int OUT_CNT_W   = 7;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [FIT_MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NEXT  = 2'd3
    } fit_mode_t;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_ALLOC  = 1'b1
    } opcode_t;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

endpackage

>>> rtl/vpfa_table.sv
// Block table storage: one write port, one read port with registered data.
// Depends on nothing; contents are undefined until written.
module vpfa_table #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 17
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/vpfa_scan_unit.sv
// Shared compare unit: checks one table entry per sample against the request
// and keeps the best candidate for the active policy. Uses vpfa_pkg.
module vpfa_scan_unit #(
    parameter int IDX_W     = 6,
    parameter int SIZE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vpfa_pkg::scan_ctl_t   ctl,
    input  vpfa_pkg::fit_mode_t   mode,
    input  logic [SIZE_BITS-1:0]  req,
    input  logic                  ent_taken,
    input  logic [SIZE_BITS-1:0]  ent_size,
    input  logic [IDX_W-1:0]      ent_idx,
    output logic                  found,
    output logic [IDX_W-1:0]      best_idx,
    output logic [SIZE_BITS-1:0]  best_size
);
    import vpfa_pkg::*;

    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [SIZE_BITS-1:0] best_size_reg;
    logic                 fits;
    logic                 better;

    assign fits   = !ent_taken && (ent_size >= req);
    // ties keep the earlier candidate, so only strict compares replace
    assign better = !found_reg
                 || ((mode == FIT_BEST)  && (ent_size < best_size_reg))
                 || ((mode == FIT_WORST) && (ent_size > best_size_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.clear) begin
            found_reg <= 1'b0;
        end else if (ctl.sample && fits && better) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!ctl.clear && ctl.sample && fits && better) begin
            best_idx_reg  <= ent_idx;
            best_size_reg <= ent_size;
        end
    end

    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_size = best_size_reg;

endmodule

>>> rtl/variable_partition_fit_allocator_unit.sv
// Channel  | Dir | Handshake          | Payload
// s_       | in  | s_tvalid/s_tready  | tdata: block_size, block_used; tuser: opcode
// m_       | out | m_tvalid/m_tready  | tdata: entry_index, entry_count; tuser: status
// cfg_     | in  | cfg_valid/cfg_ready| cfg_data: fit_mode
// Append: one table write, then the result goes into the output register. Allocate:
// the table is scanned through the read port and a decision is taken, then on a split
// the entries above the pick shift up when entries move, then one write on an exact fit
// or two on a split, and the result goes into the output register.
// The single table port pair serializes these steps. Reset is synchronous, active low;
// the table needs no clearing pass. s_tready is low while an item is in work; a
// waiting result stalls only the final step, the next item is taken meanwhile.
module variable_partition_fit_allocator_unit #(
    parameter int MAX_BLOCKS = vpfa_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = vpfa_pkg::SIZE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vpfa_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] block_size, [16] block_used
    input  logic [vpfa_pkg::S_TUSER_W-1:0]  s_tuser,   // [0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vpfa_pkg::M_TDATA_W-1:0]  m_tdata,   // [5:0] entry_index, [12:6] entry_count
    output logic [vpfa_pkg::M_TUSER_W-1:0]  m_tuser,   // [1:0] status
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vpfa_pkg::FIT_MODE_W-1:0] cfg_data   // [1:0] fit_mode
);
    import vpfa_pkg::*;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int ENTRY_W = SIZE_BITS + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE, S_APPEND, S_SCAN, S_SCAN_TAIL, S_DECIDE,
        S_SHIFT, S_SHIFT_TAIL, S_WR_REM, S_WR_PICK, S_REPLY
    } state_t;

    state_t                 state_reg;
    fit_mode_t              mode_reg;
    logic [CNT_W-1:0]       total_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [IDX_W-1:0]       last_pick_reg;
    logic                   last_valid_reg;
    logic [SIZE_BITS-1:0]   req_reg;
    logic                   used_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    status_t                status_reg;
    logic [IDX_W-1:0]       res_idx_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TUSER_W-1:0]   m_tuser_reg;

    logic [IDX_W-1:0]       total_idx;
    logic [IDX_W-1:0]       last_idx;
    logic [IDX_W-1:0]       start_pos;
    logic [IDX_W-1:0]       pos_wrap;
    logic [IDX_W-1:0]       pick_up;
    logic [SIZE_BITS-1:0]   req_in;
    logic                   in_xfer;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [ENTRY_W-1:0]     rd_data;

    scan_ctl_t              scan_ctl;
    logic                   found;
    logic [IDX_W-1:0]       best_idx;
    logic [SIZE_BITS-1:0]   best_size;

    logic [OUT_IDX_W-1:0]   idx_field;
    logic [OUT_CNT_W-1:0]   cnt_field;
    logic [M_TDATA_W-1:0]   m_tdata_next;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign req_in    = SIZE_BITS'(s_tdata[IN_SIZE_W-1:0]);

    assign total_idx = total_reg[IDX_W-1:0];
    assign last_idx  = IDX_W'(total_reg - 1'b1);
    assign pick_up   = best_idx + 1'b1;

    // next fit resumes just after its last choice, wrapping at the table end
    always_comb begin
        start_pos = '0;
        if (mode_reg == FIT_NEXT && last_valid_reg && total_reg != '0
            && (CNT_W'(last_pick_reg) + CNT_W'(1)) != total_reg) begin
            start_pos = last_pick_reg + 1'b1;
        end
    end

    assign pos_wrap = ((CNT_W'(pos_reg) + CNT_W'(1)) == total_reg) ? '0 : pos_reg + 1'b1;

    // table port steering
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg + 1'b1;
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = pos_reg;
        unique case (state_reg)
            S_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = total_idx;
                wr_data = {used_reg, req_reg};
            end
            S_SCAN: begin
                rd_en = 1'b1;
            end
            S_SHIFT: begin
                rd_en = 1'b1;
                wr_en = rd_valid_reg;
            end
            S_SHIFT_TAIL: begin
                wr_en = 1'b1;
            end
            S_WR_REM: begin
                wr_en   = 1'b1;
                wr_addr = pick_up;
                wr_data = {1'b0, best_size - req_reg};
            end
            S_WR_PICK: begin
                wr_en   = 1'b1;
                wr_addr = best_idx;
                wr_data = {1'b1, req_reg};
            end
            default: begin
            end
        endcase
    end

    assign scan_ctl.clear  = in_xfer;
    assign scan_ctl.sample = rd_valid_reg
                          && (state_reg == S_SCAN || state_reg == S_SCAN_TAIL);

    vpfa_table #(
        .DEPTH  (MAX_BLOCKS),
        .DATA_W (ENTRY_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    vpfa_scan_unit #(
        .IDX_W     (IDX_W),
        .SIZE_BITS (SIZE_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .mode      (mode_reg),
        .req       (req_reg),
        .ent_taken (rd_data[ENTRY_W-1]),
        .ent_size  (rd_data[SIZE_BITS-1:0]),
        .ent_idx   (rd_idx_reg),
        .found     (found),
        .best_idx  (best_idx),
        .best_size (best_size)
    );

    assign idx_field    = (status_reg == ST_DONE) ? OUT_IDX_W'(res_idx_reg) : '0;
    assign cnt_field    = OUT_CNT_W'(total_reg);
    assign m_tdata_next = M_TDATA_W'({cnt_field, idx_field});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            mode_reg       <= FIT_FIRST;
            total_reg      <= '0;
            last_valid_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= fit_mode_t'(cfg_data);
            end
            // the reply step below reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != S_REPLY) begin
                m_tvalid_reg <= 1'b0;
            end
            rd_valid_reg <= rd_en;
            rd_idx_reg   <= rd_addr;

            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        req_reg  <= req_in;
                        used_reg <= s_tdata[IN_SIZE_W];
                        cnt_reg  <= '0;
                        pos_reg  <= start_pos;
                        if (opcode_t'(s_tuser[0]) == OP_APPEND) begin
                            if (total_reg >= CNT_MAX) begin
                                status_reg <= ST_FULL;
                                state_reg  <= S_REPLY;
                            end else begin
                                state_reg <= S_APPEND;
                            end
                        end else begin
                            state_reg <= (total_reg == '0) ? S_DECIDE : S_SCAN;
                        end
                    end
                end
                S_APPEND: begin
                    total_reg   <= total_reg + 1'b1;
                    status_reg  <= ST_DONE;
                    res_idx_reg <= total_idx;
                    state_reg   <= S_REPLY;
                end
                S_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    pos_reg <= pos_wrap;
                    if (cnt_reg == total_reg - 1'b1) begin
                        state_reg <= S_SCAN_TAIL;
                    end
                end
                S_SCAN_TAIL: begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    priority if (!found) begin
                        status_reg <= ST_NOFIT;
                        state_reg  <= S_REPLY;
                    end else if (best_size > req_reg) begin
                        priority if (total_reg >= CNT_MAX) begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_REPLY;
                        end else if ((CNT_W'(best_idx) + CNT_W'(1)) == total_reg) begin
                            state_reg <= S_WR_REM;
                        end else begin
                            pos_reg   <= last_idx;
                            state_reg <= S_SHIFT;
                        end
                    end else begin
                        state_reg <= S_WR_PICK;
                    end
                end
                S_SHIFT: begin
                    // move entries up from the table end down to just above the pick
                    pos_reg <= pos_reg - 1'b1;
                    if (pos_reg == pick_up) begin
                        state_reg <= S_SHIFT_TAIL;
                    end
                end
                S_SHIFT_TAIL: begin
                    state_reg <= S_WR_REM;
                end
                S_WR_REM: begin
                    total_reg <= total_reg + 1'b1;
                    state_reg <= S_WR_PICK;
                end
                S_WR_PICK: begin
                    if (mode_reg == FIT_NEXT) begin
                        last_pick_reg  <= best_idx;
                        last_valid_reg <= 1'b1;
                    end
                    status_reg  <= ST_DONE;
                    res_idx_reg <= best_idx;
                    state_reg   <= S_REPLY;
                end
                S_REPLY: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= m_tdata_next;
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/vpfa_checker.sv
// Port-level checks for the fit allocator, bound to the top level.
// Uses vpfa_pkg; sees only the top level's ports.
module vpfa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [vpfa_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [vpfa_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [vpfa_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [vpfa_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [vpfa_pkg::FIT_MODE_W-1:0] cfg_data
);
    import vpfa_pkg::*;

    // a pending result is not dropped
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item in work at a time
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_DONE || m_tuser == ST_NOFIT || m_tuser == ST_FULL))
        else $error("undefined status code");

    // failed items report index zero
    a_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_DONE |-> m_tdata[OUT_IDX_W-1:0] == '0)
        else $error("nonzero index on a failed item");

endmodule

bind variable_partition_fit_allocator_unit vpfa_checker u_vpfa_checker (.*);

>>> test/tb_variable_partition_fit_allocator_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for variable_partition_fit_allocator_unit: table appends and
// first/best/worst/next fit allocation, checked against a predictor kept in this file.
// Depends on rtl/vpfa_pkg.sv and the top-level RTL with its table and compare unit.
module tb_variable_partition_fit_allocator_unit;
    import vpfa_pkg::*;

    localparam int TBL_DEPTH   = MAX_BLOCKS_DEF;
    localparam int IDLE_SETTLE = 8;
    localparam int STALL_LIMIT = 3000;
    localparam int RAND_PHASES = 16;
    localparam int PHASE_ITEMS = 58;

    typedef struct packed {
        opcode_t     op;
        logic [15:0] size;
        logic        used;
    } alloc_req_t;

    typedef struct packed {
        status_t     st;
        logic [5:0]  idx;
        logic [6:0]  cnt;
    } alloc_reply_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [FIT_MODE_W-1:0] cfg_data  = '0;

    // Predictor state: shadow of the block table and its configuration
    logic [15:0] tbl_size [TBL_DEPTH];
    bit          tbl_used [TBL_DEPTH];
    int          tbl_count = 0;
    int          rr_last   = 0;
    bit          rr_valid  = 1'b0;
    fit_mode_t   cur_mode  = FIT_FIRST;

    alloc_req_t   req_queue[$];
    alloc_reply_t reply_queue[$];
    alloc_req_t   in_flight;
    alloc_reply_t got_reply, want_reply;
    logic [15:0]  free_sizes[$];

    int items_queued = 0;
    int items_sent   = 0;
    int replies_seen = 0;
    int errors       = 0;
    int cfg_writes   = 0;
    int n_done = 0, n_nofit = 0, n_full = 0;
    int quiet_cycles = 0;

    int  send_gap_pct   = 0;
    int  recv_stall_pct = 0;
    bit  drain_each     = 1'b0;

    logic [15:0] size_pool [12] = '{16'd1, 16'd2, 16'd3, 16'd7, 16'd16, 16'd100, 16'd255,
                                    16'd256, 16'd1000, 16'd4096, 16'h8000, 16'hFFFF};

    variable_partition_fit_allocator_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [15:0] block_size, [16] block_used
        .s_tuser   (s_tuser),    // [0] opcode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [5:0] entry_index, [12:6] entry_count
        .m_tuser   (m_tuser),    // [1:0] status
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)    // [1:0] fit_mode
    );

    always #5 aclk = ~aclk;

    // Applies one request to the shadow table and returns the reply it should produce
    function automatic alloc_reply_t predict_table_op(alloc_req_t r);
        alloc_reply_t rep;
        int  n, pick, pos;
        bit  found;
        n     = tbl_count;
        pick  = 0;
        found = 1'b0;
        rep.st  = ST_DONE;
        rep.idx = '0;
        if (r.op == OP_APPEND) begin
            if (n >= TBL_DEPTH) begin
                rep.st = ST_FULL;
            end else begin
                tbl_size[n] = r.size;
                tbl_used[n] = r.used;
                tbl_count   = n + 1;
                rep.idx     = 6'(n);
            end
        end else begin
            if (cur_mode == FIT_NEXT) begin
                pos = (n > 0 && rr_valid) ? (rr_last + 1) % n : 0;
                for (int i = 0; i < n && !found; i++) begin
                    if (!tbl_used[pos] && tbl_size[pos] >= r.size) begin
                        pick  = pos;
                        found = 1'b1;
                    end else begin
                        pos = (pos + 1 == n) ? 0 : pos + 1;
                    end
                end
            end else begin
                for (int i = 0; i < n && !(found && cur_mode == FIT_FIRST); i++) begin
                    if (!tbl_used[i] && tbl_size[i] >= r.size) begin
                        if (!found ||
                            (cur_mode == FIT_BEST  && tbl_size[i] < tbl_size[pick]) ||
                            (cur_mode == FIT_WORST && tbl_size[i] > tbl_size[pick])) begin
                            pick  = i;
                            found = 1'b1;
                        end
                    end
                end
            end

            if (!found) begin
                rep.st = ST_NOFIT;
            end else if (tbl_size[pick] > r.size && n >= TBL_DEPTH) begin
                rep.st = ST_FULL;   // split needs a free slot; nothing changes
            end else begin
                if (tbl_size[pick] > r.size) begin
                    for (int i = n; i > pick; i--) begin
                        tbl_size[i] = tbl_size[i-1];
                        tbl_used[i] = tbl_used[i-1];
                    end
                    tbl_size[pick+1] = tbl_size[pick+1] - r.size;
                    tbl_size[pick]   = r.size;
                    tbl_count        = n + 1;
                end
                tbl_used[pick] = 1'b1;
                if (cur_mode == FIT_NEXT) begin
                    rr_last  = pick;
                    rr_valid = 1'b1;
                end
                rep.idx = 6'(pick);
            end
        end
        rep.cnt = 7'(tbl_count);
        return rep;
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    task automatic push_req(opcode_t op, logic [15:0] size, logic used);
        alloc_req_t r;
        r.op   = op;
        r.size = size;
        r.used = used;
        req_queue = {req_queue, r};
        items_queued++;
    endtask

    task automatic write_fit_mode(fit_mode_t m);
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_mode = m;
        cfg_writes++;
    endtask

    // Wait until every queued request went in and its reply came back
    task automatic drain();
        while (items_sent != items_queued || reply_queue.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                reply_queue = {reply_queue, predict_table_op(in_flight)};
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (req_queue.size() > 0 && $urandom_range(0, 99) >= send_gap_pct &&
                    !(drain_each && reply_queue.size() > 0)) begin
                    in_flight = req_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, in_flight.used, in_flight.size};
                    s_tuser  <= in_flight.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_reply.st  = status_t'(m_tuser);
                got_reply.idx = m_tdata[5:0];
                got_reply.cnt = m_tdata[12:6];
                replies_seen++;
                if (reply_queue.size() == 0) begin
                    $display("%0t: unexpected reply, expected none, got st=%0d idx=%0d cnt=%0d",
                             $time, got_reply.st, got_reply.idx, got_reply.cnt);
                    errors++;
                end else begin
                    want_reply = reply_queue.pop_front();
                    check_field("st",  16'(want_reply.st),  16'(got_reply.st));
                    check_field("idx", 16'(want_reply.idx), 16'(got_reply.idx));
                    check_field("cnt", 16'(want_reply.cnt), 16'(got_reply.cnt));
                    case (want_reply.st)
                        ST_DONE:  n_done++;
                        ST_NOFIT: n_nofit++;
                        default:  n_full++;
                    endcase
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          sel;
        logic [15:0] sz;
        fit_mode_t   m;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: first fit, empty table, bit extremes, exact fit, zero request
        write_fit_mode(FIT_FIRST);
        push_req(OP_ALLOC,  16'd1,    1'b0);   // empty table, no fit
        push_req(OP_APPEND, 16'd100,  1'b0);
        push_req(OP_APPEND, 16'hFFFF, 1'b0);
        push_req(OP_APPEND, 16'd1,    1'b1);
        push_req(OP_APPEND, 16'd40,   1'b0);
        push_req(OP_APPEND, 16'd100,  1'b0);
        push_req(OP_ALLOC,  16'd100,  1'b0);   // exact fit at the head
        push_req(OP_ALLOC,  16'd0,    1'b0);   // zero request splits off an empty used piece
        push_req(OP_ALLOC,  16'hFFFF, 1'b0);   // exact fit on the remainder
        push_req(OP_ALLOC,  16'd500,  1'b1);   // nothing large enough
        drain();

        write_fit_mode(FIT_BEST);
        push_req(OP_APPEND, 16'd50, 1'b0);
        push_req(OP_APPEND, 16'd30, 1'b0);
        push_req(OP_APPEND, 16'd30, 1'b0);
        push_req(OP_ALLOC,  16'd25, 1'b0);     // tie between 30s goes low
        push_req(OP_ALLOC,  16'd30, 1'b0);
        drain();

        write_fit_mode(FIT_WORST);
        push_req(OP_ALLOC, 16'd10,   1'b0);
        push_req(OP_ALLOC, 16'd10,   1'b0);
        push_req(OP_ALLOC, 16'hFFFF, 1'b0);
        drain();

        write_fit_mode(FIT_NEXT);
        push_req(OP_ALLOC, 16'd5, 1'b0);
        push_req(OP_ALLOC, 16'd5, 1'b0);
        push_req(OP_ALLOC, 16'd5, 1'b0);
        push_req(OP_ALLOC, 16'd1, 1'b0);
        drain();

        // Random phases: policy and idling change only while the block is idle
        for (int p = 0; p < RAND_PHASES; p++) begin
            m = (p < 4) ? fit_mode_t'(p) : fit_mode_t'($urandom_range(0, 3));
            write_fit_mode(m);
            case ((p + p / 4) % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 50; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 50; end
                default: begin send_gap_pct = 23; recv_stall_pct = 23; end
            endcase
            drain_each = (p == 6);

            // Sizes of free blocks now in the table make exact fits likely
            free_sizes.delete();
            for (int i = 0; i < tbl_count; i++)
                if (!tbl_used[i]) free_sizes = {free_sizes, tbl_size[i]};

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    sz = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 65535))
                                                     : size_pool[$urandom_range(0, 11)];
                    push_req(OP_APPEND, sz, ($urandom_range(0, 3) == 0));
                end else begin
                    sel = $urandom_range(0, 9);
                    if (sel < 4 && free_sizes.size() > 0)
                        sz = free_sizes[$urandom_range(0, free_sizes.size() - 1)];
                    else if (sel < 6)
                        sz = 16'($urandom_range(1, 64));
                    else if (sel < 8)
                        sz = size_pool[$urandom_range(0, 11)];
                    else
                        sz = 16'($urandom_range(1, 65535));
                    push_req(OP_ALLOC, sz, 1'($urandom_range(0, 1)));
                end
            end
            drain();
        end

        drain_each = 1'b0;
        $display("covered %0d requests, %0d policy writes; %0d done, %0d no fit, %0d full",
                 items_sent, cfg_writes, n_done, n_nofit, n_full);
        $display("%0d replies checked, %0d mismatches, table ended at %0d entries",
                 replies_seen, errors, tbl_count);
        if (errors == 0 && reply_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
